// ===== rtl/gbfs_pkg.sv =====
// ----------------------------------------------------------------------------
// gbfs_pkg: shared types and constants for the grid nearest-target search
// Cell packing, status and direction codes, map geometry defaults.
// ----------------------------------------------------------------------------
package gbfs_pkg;

	localparam int unsigned DefRows = 8;
	localparam int unsigned DefCols = 8;

	localparam logic [4:0] MaskReset = 5'd9;

	localparam logic [1:0] StFound   = 2'd0;
	localparam logic [1:0] StNone    = 2'd1;
	localparam logic [1:0] StBadStart = 2'd2;

	localparam logic [2:0] DirNorth = 3'd0;
	localparam logic [2:0] DirSouth = 3'd1;
	localparam logic [2:0] DirWest  = 3'd2;
	localparam logic [2:0] DirEast  = 3'd3;
	localparam logic [2:0] DirNone  = 3'd4;

	localparam logic [1:0] ModeUnknown  = 2'd0;
	localparam logic [1:0] ModeLandmark = 2'd1;
	localparam logic [1:0] ModeNoMatch  = 2'd2;
	localparam logic [1:0] ModeReserved = 2'd3;

	localparam logic KindWrite  = 1'b0;
	localparam logic KindSearch = 1'b1;

	typedef struct packed {
		logic [2:0] lm_kind;
		logic       lm_flag;
		logic [2:0] terrain;
	} cell_t;

endpackage

// ===== rtl/grid_bfs_nearest_target_unit.sv =====
// ----------------------------------------------------------------------------
// grid_bfs_nearest_target_unit: breadth-first nearest-target search on a grid
// Map write requests and search requests share one input channel.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready): kind 0 writes one map cell
//   and produces no result. kind 1 starts a search from cell_row/cell_col.
//   out channel (out_valid/out_ready): one result per search request.
//   cfg channel (cfg_valid/cfg_ready): blocked_type_mask, taken only when idle.
// Sequence: a search with a bad start shows its result the cycle after it is
//   taken. Otherwise a pass over every cell wipes the visited map, then each
//   dequeued cell goes through pop, queue read and two neighbour sweeps of 4
//   reads, each read issuing its address and then checking its data through
//   the single map read port. in_ready is low meanwhile.
// Reset: mask returns to 9, queue pointers clear. The map holds garbage
//   until written.
// Stall: a result waits in the output register; the block takes the next
//   write request meanwhile but holds searches until the result leaves.
// ----------------------------------------------------------------------------
module grid_bfs_nearest_target_unit #(
	parameter int unsigned GRID_ROWS = gbfs_pkg::DefRows,
	parameter int unsigned GRID_COLS = gbfs_pkg::DefCols
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  logic [2:0] cell_row,
	input  logic [2:0] cell_col,
	input  logic [2:0] terrain_code,
	input  logic       landmark_flag,
	input  logic [2:0] landmark_kind,
	input  logic [1:0] search_mode,
	input  logic [2:0] target_landmark,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic [2:0] found_row,
	output logic [2:0] found_col,
	output logic [2:0] direction,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [4:0] cfg_data
);

	logic [4:0] mask_q;
	logic busy, done;
	logic [1:0] r_st;
	logic [2:0] r_row, r_col, r_dir;
	logic in_ok;
	logic bad_start;

	assign cfg_ready = !busy;
	assign in_ready = !busy && (kind == gbfs_pkg::KindWrite || !out_valid);
	assign in_ok = in_valid && in_ready;
	assign bad_start = (32'(cell_row) >= GRID_ROWS) || (32'(cell_col) >= GRID_COLS);

	gbfs_seq #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_seq (
		.clk(clk), .arst_n(arst_n),
		.start(in_ok && kind != gbfs_pkg::KindWrite && !bad_start),
		.start_row(cell_row), .start_col(cell_col),
		.mode(search_mode), .target(target_landmark), .block_mask(mask_q),
		.write_en(in_ok && kind == gbfs_pkg::KindWrite),
		.write_row(cell_row), .write_col(cell_col),
		.write_cell({landmark_kind, landmark_flag, terrain_code}),
		.busy(busy), .done(done),
		.res_status(r_st), .res_row(r_row), .res_col(r_col), .res_dir(r_dir)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= gbfs_pkg::MaskReset;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mask_q <= cfg_data;
			end
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (done || (in_ok && kind != gbfs_pkg::KindWrite && bad_start)) begin
				out_valid <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			status <= r_st;
			found_row <= r_row;
			found_col <= r_col;
			direction <= r_dir;
		end else if (in_ok && kind != gbfs_pkg::KindWrite && bad_start) begin
			status <= gbfs_pkg::StBadStart;
			found_row <= '0;
			found_col <= '0;
			direction <= gbfs_pkg::DirNone;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !out_valid) else $error("result overwritten");
	a_busy_block: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ready) else $error("accepted while searching");
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done outside search");

endmodule

// ===== rtl/gbfs_ram.sv =====
// ----------------------------------------------------------------------------
// gbfs_ram: generic single-port write, single-port read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gbfs_ram #(
	parameter int unsigned WIDTH = 7,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/gbfs_seq.sv =====
// ----------------------------------------------------------------------------
// gbfs_seq: search sequencer
// Walks the frontier queue one cell at a time; a single neighbour-address
// unit and a single map read port are reused for all four directions.
// ----------------------------------------------------------------------------
module gbfs_seq #(
	parameter int unsigned GRID_ROWS = gbfs_pkg::DefRows,
	parameter int unsigned GRID_COLS = gbfs_pkg::DefCols
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [2:0]  start_row,
	input  logic [2:0]  start_col,
	input  logic [1:0]  mode,
	input  logic [2:0]  target,
	input  logic [4:0]  block_mask,
	input  logic        write_en,
	input  logic [2:0]  write_row,
	input  logic [2:0]  write_col,
	input  gbfs_pkg::cell_t write_cell,
	output logic        busy,
	output logic        done,
	output logic [1:0]  res_status,
	output logic [2:0]  res_row,
	output logic [2:0]  res_col,
	output logic [2:0]  res_dir
);

	localparam int unsigned Cells = GRID_ROWS * GRID_COLS;
	localparam int unsigned AW = $clog2(Cells);
	localparam int unsigned RW = $clog2(GRID_ROWS);
	localparam int unsigned CW = $clog2(GRID_COLS);
	localparam int unsigned QW = $clog2(Cells + 1);
	localparam int unsigned EW = RW + CW;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CLEAR = 7'b0000010,
		S_POP   = 7'b0000100,
		S_QRD   = 7'b0001000,
		S_MATCH = 7'b0010000,
		S_EXP   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [QW-1:0] head_q, tail_q;
	logic [AW-1:0] clr_q;
	logic [1:0] dir_q;
	logic       wait_q;
	logic [RW-1:0] cr_q;
	logic [CW-1:0] cc_q;
	logic [1:0] mode_q;
	logic [2:0] target_q;

	// shared neighbour address unit
	logic          nb_ok;
	logic [RW-1:0] nr;
	logic [CW-1:0] nc;
	always_comb begin
		nr = cr_q;
		nc = cc_q;
		nb_ok = 1'b0;
		case (dir_q)
			2'd0: begin nb_ok = (cr_q != '0); nr = cr_q - RW'(1); end
			2'd1: begin nb_ok = (32'(cr_q) != GRID_ROWS - 1); nr = cr_q + RW'(1); end
			2'd2: begin nb_ok = (cc_q != '0); nc = cc_q - CW'(1); end
			2'd3: begin nb_ok = (32'(cc_q) != GRID_COLS - 1); nc = cc_q + CW'(1); end
			default: nb_ok = 1'b0;
		endcase
	end
	logic [AW-1:0] nidx;
	assign nidx = AW'(32'(nr) * GRID_COLS + 32'(nc));
	logic [AW-1:0] cidx;
	assign cidx = AW'(32'(cr_q) * GRID_COLS + 32'(cc_q));

	// map: write port fed by the write path, read port by the neighbour address
	logic [AW-1:0] waddr;
	logic          wok;
	assign wok   = (32'(write_row) < GRID_ROWS) && (32'(write_col) < GRID_COLS);
	assign waddr = AW'(32'(write_row) * GRID_COLS + 32'(write_col));
	gbfs_pkg::cell_t mrd;
	gbfs_ram #(.WIDTH(7), .DEPTH(Cells)) u_map (
		.clk(clk), .we(write_en && wok), .waddr(waddr), .wdata(write_cell),
		.raddr(nidx), .rdata(mrd)
	);

	// frontier queue, one row and column per entry
	logic          q_we;
	logic [AW-1:0] q_rd;
	logic [AW-1:0] q_wa;
	logic [EW-1:0] q_wd;
	logic [EW-1:0] q_rd_data;
	assign q_rd = head_q[AW-1:0];
	gbfs_ram #(.WIDTH(EW), .DEPTH(Cells)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_rd), .rdata(q_rd_data)
	);

	// visited map: before each search, a pass over every cell marks only the start
	logic          vis_we;
	logic [AW-1:0] vis_wa;
	logic [0:0]    vis_wd;
	logic [0:0]    vis_rd;
	gbfs_ram #(.WIDTH(1), .DEPTH(Cells)) u_visited (
		.clk(clk), .we(vis_we), .waddr(vis_wa), .wdata(vis_wd), .raddr(nidx), .rdata(vis_rd)
	);

	logic is_match, passable;
	always_comb begin
		is_match = 1'b0;
		if (mode_q == gbfs_pkg::ModeUnknown) begin
			is_match = (mrd.terrain == 3'd0);
		end else if (mode_q == gbfs_pkg::ModeLandmark) begin
			is_match = (mrd.lm_kind == target_q);
		end
		passable = (mrd.terrain > 3'd4) ? 1'b1 : !block_mask[mrd.terrain];
	end

	logic exp_push;
	assign exp_push = (state_q == S_EXP) && wait_q && nb_ok && !vis_rd[0] && passable
		&& (32'(tail_q) < Cells);

	always_comb begin
		q_we = exp_push;
		q_wa = tail_q[AW-1:0];
		q_wd = {nr, nc};
		if (state_q == S_IDLE) begin
			q_we = start;
			q_wa = '0;
			q_wd = {RW'(start_row), CW'(start_col)};
		end
	end

	always_comb begin
		if (state_q == S_CLEAR) begin
			vis_we = 1'b1;
			vis_wa = clr_q;
			vis_wd = (clr_q == cidx);
		end else begin
			vis_we = exp_push;
			vis_wa = nidx;
			vis_wd = 1'b1;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			clr_q   <= '0;
			dir_q   <= '0;
			wait_q  <= 1'b0;
			cr_q    <= '0;
			cc_q    <= '0;
			res_status <= '0;
			res_row <= '0;
			res_col <= '0;
			res_dir <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						clr_q   <= '0;
						head_q  <= '0;
						tail_q  <= QW'(1);
						cr_q    <= RW'(start_row);
						cc_q    <= CW'(start_col);
						state_q <= S_CLEAR;
					end
				end
				S_CLEAR: begin
					if (32'(clr_q) == Cells - 1) begin
						state_q <= S_POP;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				S_POP: begin
					if (head_q == tail_q || 32'(head_q) >= Cells) begin
						res_status <= gbfs_pkg::StNone;
						res_row <= '0;
						res_col <= '0;
						res_dir <= gbfs_pkg::DirNone;
						state_q <= S_DONE;
					end else begin
						state_q <= S_QRD;
					end
				end
				S_QRD: begin
					cr_q <= q_rd_data[EW-1:CW];
					cc_q <= q_rd_data[CW-1:0];
					head_q <= head_q + QW'(1);
					dir_q <= '0;
					wait_q <= 1'b0;
					state_q <= S_MATCH;
				end
				S_MATCH: begin
					// address issued first, data checked the next cycle
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else begin
						wait_q <= 1'b0;
						if (nb_ok && is_match) begin
							res_status <= gbfs_pkg::StFound;
							res_row <= 3'(cr_q);
							res_col <= 3'(cc_q);
							res_dir <= {1'b0, dir_q};
							state_q <= S_DONE;
						end else if (dir_q == 2'd3) begin
							dir_q <= '0;
							state_q <= S_EXP;
						end else begin
							dir_q <= dir_q + 2'd1;
						end
					end
				end
				S_EXP: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else begin
						wait_q <= 1'b0;
						if (q_we) begin
							tail_q <= tail_q + QW'(1);
						end
						if (dir_q == 2'd3) begin
							state_q <= S_POP;
						end else begin
							dir_q <= dir_q + 2'd1;
						end
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			mode_q <= mode;
			target_q <= target;
		end
	end

	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(tail_q) <= Cells) else $error("queue tail overran");
	a_head_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q) else $error("head passed tail");
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");

endmodule

// ===== tb/sv/grid_bfs_nearest_target_unit_tb.sv =====
// ----------------------------------------------------------------------------
// grid_bfs_nearest_target_unit_tb: self-checking bench for the grid search
// Loads map cells and runs search requests under random idling and stalls,
// predicts each search result with a local breadth-first walk and compares.
// ----------------------------------------------------------------------------
module grid_bfs_nearest_target_unit_tb;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] row;
		logic [2:0] col;
		logic [2:0] dir;
	} search_res_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       kind;
	logic [2:0] cell_row;
	logic [2:0] cell_col;
	logic [2:0] terrain_code;
	logic       landmark_flag;
	logic [2:0] landmark_kind;
	logic [1:0] search_mode;
	logic [2:0] target_landmark;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] status;
	logic [2:0] found_row;
	logic [2:0] found_col;
	logic [2:0] direction;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [4:0] cfg_data;

	gbfs_pkg::cell_t grid_map [64];
	logic [4:0]  blocked_mask;
	search_res_t pending_results [$];
	int          mismatch_count;
	int          results_seen;

	grid_bfs_nearest_target_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind),
		.cell_row(cell_row), .cell_col(cell_col), .terrain_code(terrain_code),
		.landmark_flag(landmark_flag), .landmark_kind(landmark_kind),
		.search_mode(search_mode), .target_landmark(target_landmark),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.found_row(found_row), .found_col(found_col), .direction(direction),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	initial begin
		#10000000;
		$display("grid_bfs_nearest_target_unit_tb: FAIL");
		$finish;
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic target_at(int r, int c, logic [1:0] mode, logic [2:0] tgt);
		gbfs_pkg::cell_t e;
		if (r < 0 || r > 7 || c < 0 || c > 7) return 1'b0;
		e = grid_map[r * 8 + c];
		if (mode == gbfs_pkg::ModeUnknown) return e.terrain == 3'd0;
		if (mode == gbfs_pkg::ModeLandmark) return e.lm_kind == tgt;
		return 1'b0;
	endfunction

	function automatic search_res_t nearest_target(logic [2:0] r0, logic [2:0] c0,
			logic [1:0] mode, logic [2:0] tgt);
		search_res_t res;
		logic [63:0] seen;
		int          frontier [64];
		int          head, tail, cur, cr, cc, nr, nc, ni;
		int          dr [4];
		int          dc [4];
		gbfs_pkg::cell_t e;
		dr = '{-1, 1, 0, 0};
		dc = '{0, 0, -1, 1};
		res = '{status: gbfs_pkg::StNone, row: 3'd0, col: 3'd0, dir: gbfs_pkg::DirNone};
		seen = '0;
		head = 0;
		tail = 1;
		frontier[0] = r0 * 8 + c0;
		seen[r0 * 8 + c0] = 1'b1;
		while (head < tail) begin
			cur = frontier[head];
			head++;
			cr = cur / 8;
			cc = cur % 8;
			for (int d = 0; d < 4; d++) begin
				if (target_at(cr + dr[d], cc + dc[d], mode, tgt)) begin
					res = '{status: gbfs_pkg::StFound, row: cr[2:0], col: cc[2:0],
						dir: d[2:0]};
					return res;
				end
			end
			for (int d = 0; d < 4; d++) begin
				nr = cr + dr[d];
				nc = cc + dc[d];
				if (nr >= 0 && nr < 8 && nc >= 0 && nc < 8) begin
					ni = nr * 8 + nc;
					e = grid_map[ni];
					if (!seen[ni] && (e.terrain > 3'd4 || !blocked_mask[e.terrain])) begin
						seen[ni] = 1'b1;
						frontier[tail] = ni;
						tail++;
					end
				end
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %0d: %s got %0d want %0d", results_seen, what, got, want);
		mismatch_count++;
	endtask

	// check each result against the oldest prediction
	always @(posedge clk) begin
		search_res_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result status", status, -1);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) report_mismatch("status", status, want.status);
				if (found_row !== want.row) report_mismatch("found_row", found_row, want.row);
				if (found_col !== want.col) report_mismatch("found_col", found_col, want.col);
				if (direction !== want.dir) report_mismatch("direction", direction, want.dir);
			end
		end
	end

	// random receiver stalls, with quiet stretches
	initial begin
		int n;
		out_ready = 1'b0;
		forever begin
			n = gap_len();
			out_ready <= (n == 0);
			@(posedge clk);
			repeat (n) @(posedge clk);
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// valid stays high after an accept until the next request or an idle stretch
	task automatic send_request(logic k, logic [2:0] r, logic [2:0] c, logic [2:0] t,
			logic f, logic [2:0] lk, logic [1:0] m, logic [2:0] tg);
		int n;
		n = gap_len();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		cell_row <= r;
		cell_col <= c;
		terrain_code <= t;
		landmark_flag <= f;
		landmark_kind <= lk;
		search_mode <= m;
		target_landmark <= tg;
		do @(posedge clk); while (!in_ready);
		if (k == gbfs_pkg::KindWrite) grid_map[r * 8 + c] = '{lm_kind: lk, lm_flag: f, terrain: t};
		else pending_results.push_back(nearest_target(r, c, m, tg));
	endtask

	task automatic write_cell(int r, int c, logic [2:0] t, logic [2:0] lk);
		send_request(gbfs_pkg::KindWrite, 3'(r), 3'(c), t, 1'($urandom_range(0, 1)), lk,
			2'($urandom), 3'($urandom));
	endtask

	task automatic run_search(int r, int c, logic [1:0] m, logic [2:0] tg);
		send_request(gbfs_pkg::KindSearch, 3'(r), 3'(c), 3'($urandom), 1'($urandom),
			3'($urandom), m, tg);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_mask(logic [4:0] m);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		blocked_mask = m;
	endtask

	function automatic logic [2:0] rand_terrain();
		return ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
			: 3'($urandom_range(1, 4));
	endfunction

	task automatic fill_map(int unknown_pct);
		for (int i = 0; i < 64; i++)
			write_cell(i / 8, i % 8,
				($urandom_range(0, 99) < unknown_pct) ? 3'd0 : rand_terrain(),
				($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd0);
	endtask

	task automatic test_directed();
		// plain sand map, no targets anywhere
		for (int i = 0; i < 64; i++) write_cell(i / 8, i % 8, 3'd2, 3'd0);
		run_search(3, 3, gbfs_pkg::ModeUnknown, 3'd0);
		run_search(0, 0, gbfs_pkg::ModeNoMatch, 3'd0);
		run_search(7, 7, gbfs_pkg::ModeReserved, 3'd7);
		// corner targets, each direction
		write_cell(0, 0, 3'd0, 3'd7);
		run_search(1, 0, gbfs_pkg::ModeUnknown, 3'd0);
		run_search(0, 1, gbfs_pkg::ModeUnknown, 3'd0);
		run_search(7, 7, gbfs_pkg::ModeUnknown, 3'd0);
		run_search(0, 0, gbfs_pkg::ModeUnknown, 3'd0);
		run_search(7, 7, gbfs_pkg::ModeLandmark, 3'd7);
		write_cell(7, 7, 3'd5, 3'd4);
		run_search(6, 7, gbfs_pkg::ModeLandmark, 3'd4);
		run_search(7, 6, gbfs_pkg::ModeLandmark, 3'd4);
		// wall of water cuts the map; start cell itself blocked
		for (int c = 0; c < 8; c++) write_cell(4, c, 3'd3, 3'd0);
		run_search(4, 4, gbfs_pkg::ModeLandmark, 3'd4);
		run_search(5, 0, gbfs_pkg::ModeUnknown, 3'd0);
	endtask

	task automatic test_mask_settings();
		logic [4:0] masks [5];
		masks = '{5'd0, 5'd31, 5'd6, 5'd16, 5'd9};
		foreach (masks[i]) begin
			write_mask(masks[i]);
			fill_map(8);
			repeat (8) run_search($urandom, $urandom, gbfs_pkg::ModeUnknown, 3'd0);
		end
	endtask

	task automatic test_random();
		int m;
		for (int round = 0; round < 30; round++) begin
			if (round % 10 == 5) write_mask(5'($urandom));
			if (round % 4 == 0) fill_map($urandom_range(0, 12));
			for (int k = 0; k < 20; k++) begin
				if ($urandom_range(0, 2) == 0) begin
					write_cell($urandom, $urandom,
						($urandom_range(0, 7) == 0) ? 3'd0 : rand_terrain(),
						3'($urandom));
				end else begin
					m = $urandom_range(0, 9);
					run_search($urandom, $urandom,
						(m < 4) ? gbfs_pkg::ModeUnknown
						: (m < 9) ? gbfs_pkg::ModeLandmark : 2'($urandom_range(2, 3)),
						3'($urandom));
				end
			end
			// let every answer arrive before sending more
			if (round == 20) begin
				in_valid <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = 1'b0;
		cell_row = '0;
		cell_col = '0;
		terrain_code = '0;
		landmark_flag = 1'b0;
		landmark_kind = '0;
		search_mode = '0;
		target_landmark = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		blocked_mask = gbfs_pkg::MaskReset;
		mismatch_count = 0;
		results_seen = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_mask_settings();
		test_random();
		drain_results();
		if (mismatch_count == 0) begin
			$display("grid_bfs_nearest_target_unit_tb: PASS");
		end else begin
			$display("grid_bfs_nearest_target_unit_tb: FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/gbfs_pkg.sv
rtl/gbfs_ram.sv
rtl/gbfs_seq.sv
rtl/grid_bfs_nearest_target_unit.sv
tb/sv/grid_bfs_nearest_target_unit_tb.sv
